// ===== hdl/expf_pkg.sv =====
package expf_pkg;

	localparam int NumStages = 20;
	localparam int NumSlots = 14;
	localparam int SlotBase = 5;

	localparam logic [31:0] F_INV_LN2 = 32'h3FB8AA3B;
	localparam logic [31:0] F_LN2_HI = 32'h3F317218;
	localparam logic [31:0] F_LN2_LO = 32'hB102E308;
	localparam logic [31:0] F_CLAMP = 32'h42B00000;
	localparam logic [31:0] F_CLAMP_NEG = 32'hC2B00000;
	localparam logic [31:0] F_ONE = 32'h3F800000;
	localparam logic [31:0] F_QNAN = 32'h7FC00000;
	localparam logic [31:0] F_PINF = 32'h7F800000;
	localparam logic [31:0] F_ZERO = 32'h00000000;

	typedef enum logic [1:0] {
		OP_MUL,
		OP_ADD,
		OP_PASS
	} slot_op_t;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] r;
		logic [31:0] acc;
		logic signed [8:0] n;
		logic spec;
		logic [31:0] sval;
	} pipe_t;

	function automatic logic [31:0] coef(logic mode, logic [2:0] k);
		logic [31:0] c;
		if (!mode) begin
			case (k)
				3'd0: c = 32'h3F800000;
				3'd1: c = 32'h3F800000;
				3'd2: c = 32'h3EFFFFF2;
				3'd3: c = 32'h3E2AABBF;
				3'd4: c = 32'h3D2A9436;
				3'd5: c = 32'h3C098C59;
				3'd6: c = 32'h3AA8E9B6;
				default: c = 32'h39939330;
			endcase
		end else begin
			case (k)
				3'd0: c = 32'h3F800000;
				3'd1: c = 32'h3F800000;
				3'd2: c = 32'h3F000000;
				3'd3: c = 32'h3E2AAAAB;
				3'd4: c = 32'h3D2AAAAB;
				3'd5: c = 32'h3C088889;
				3'd6: c = 32'h3AB60B61;
				default: c = 32'h39500D01;
			endcase
		end
		return c;
	endfunction

	// Binary32 multiply of finite operands, round to nearest even, subnormals kept.
	function automatic logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
		logic sg;
		logic [23:0] ma, mb;
		logic [47:0] p;
		logic [63:0] pw, m;
		logic g, st;
		logic [31:0] tv;
		int ea, eb, lead, e, sh, ebf, tot;
		sg = a[31] ^ b[31];
		ea = (a[30:23] == 8'd0) ? 1 : int'(a[30:23]);
		eb = (b[30:23] == 8'd0) ? 1 : int'(b[30:23]);
		ma = {(a[30:23] != 8'd0), a[22:0]};
		mb = {(b[30:23] != 8'd0), b[22:0]};
		p = ma * mb;
		if (p == 48'd0) begin
			return {sg, 31'd0};
		end
		lead = 0;
		for (int i = 0; i < 48; i++) begin
			if (p[i]) begin
				lead = i;
			end
		end
		e = lead + ea + eb - 173;
		sh = lead - 23;
		if (e < 1) begin
			sh = sh + (1 - e);
		end
		if (sh > 50) begin
			sh = 50;
		end
		pw = {16'd0, p};
		if (sh <= 0) begin
			m = pw << (-sh);
			g = 1'b0;
			st = 1'b0;
		end else begin
			m = pw >> sh;
			g = pw[sh-1];
			st = |(pw & ((64'd1 << (sh - 1)) - 64'd1));
		end
		m = m + {63'd0, g & (st | m[0])};
		if (e >= 255) begin
			return {sg, F_PINF[30:0]};
		end
		ebf = (e >= 1) ? (e - 1) : 0;
		tot = ebf * 8388608 + int'(m[24:0]);
		if (tot >= 255 * 8388608) begin
			return {sg, F_PINF[30:0]};
		end
		tv = 32'(tot);
		return {sg, tv[30:0]};
	endfunction

	// Binary32 add of finite operands, round to nearest even.
	function automatic logic [31:0] fp_add(logic [31:0] ai, logic [31:0] bi);
		logic [31:0] a, b, tv;
		logic sa, sb, g, st;
		logic [23:0] ma, mb;
		logic [26:0] ta, tb, mbs, mm;
		logic [27:0] s;
		logic [24:0] m;
		int ea, eb, d, lead, shl, e, tot;
		if (ai[30:0] < bi[30:0]) begin
			a = bi;
			b = ai;
		end else begin
			a = ai;
			b = bi;
		end
		sa = a[31];
		sb = b[31];
		ea = (a[30:23] == 8'd0) ? 1 : int'(a[30:23]);
		eb = (b[30:23] == 8'd0) ? 1 : int'(b[30:23]);
		ma = {(a[30:23] != 8'd0), a[22:0]};
		mb = {(b[30:23] != 8'd0), b[22:0]};
		d = ea - eb;
		ta = {ma, 3'd0};
		tb = {mb, 3'd0};
		if (d >= 27) begin
			mbs = {26'd0, |tb};
		end else begin
			mbs = (tb >> d) | {26'd0, |(tb & ((27'd1 << d) - 27'd1))};
		end
		if (sa == sb) begin
			s = {1'b0, ta} + {1'b0, mbs};
		end else begin
			s = {1'b0, ta} - {1'b0, mbs};
		end
		if (s == 28'd0) begin
			return {sa & sb, 31'd0};
		end
		lead = 0;
		for (int i = 0; i < 28; i++) begin
			if (s[i]) begin
				lead = i;
			end
		end
		if (lead == 27) begin
			mm = s[27:1] | {26'd0, s[0]};
			e = ea + 1;
		end else begin
			shl = 26 - lead;
			if (shl > ea - 1) begin
				shl = ea - 1;
			end
			mm = s[26:0] << shl;
			e = ea - shl;
		end
		g = mm[2];
		st = |mm[1:0];
		m = {1'b0, mm[26:3]} + {24'd0, g & (st | mm[3])};
		if (e >= 255) begin
			return {sa, F_PINF[30:0]};
		end
		tot = (e - 1) * 8388608 + int'(m);
		if (tot >= 255 * 8388608) begin
			return {sa, F_PINF[30:0]};
		end
		tv = 32'(tot);
		return {sa, tv[30:0]};
	endfunction

	function automatic logic [31:0] fp_sub(logic [31:0] a, logic [31:0] b);
		return fp_add(a, {~b[31], b[30:0]});
	endfunction

	// Round to integer, half away from zero; the magnitude stays below 128.
	function automatic logic signed [8:0] round_n(logic [31:0] f);
		logic [24:0] mant;
		logic [24:0] mag;
		int e, sh;
		e = int'(f[30:23]);
		if (e < 126) begin
			mag = 25'd0;
		end else begin
			sh = 150 - e;
			mant = {2'b01, f[22:0]};
			mag = (mant + (25'd1 << (sh - 1))) >> sh;
		end
		return f[31] ? -$signed({1'b0, mag[7:0]}) : $signed({1'b0, mag[7:0]});
	endfunction

	function automatic logic [31:0] int_to_fp(logic signed [8:0] n);
		logic [7:0] mag;
		logic [30:0] fr;
		int lead;
		mag = n[8] ? 8'(-n) : n[7:0];
		if (mag == 8'd0) begin
			return F_ZERO;
		end
		lead = 0;
		for (int i = 0; i < 8; i++) begin
			if (mag[i]) begin
				lead = i;
			end
		end
		fr = {23'd0, mag} << (23 - lead);
		return {n[8], 8'(127 + lead), fr[22:0]};
	endfunction

	// 2^n for n in the range -127 to 127.
	function automatic logic [31:0] pow2(logic signed [8:0] n);
		logic signed [8:0] be;
		be = n + 9'sd127;
		if (n >= -9'sd126) begin
			return {1'b0, be[7:0], 23'd0};
		end
		return 32'h00400000;
	endfunction

	function automatic slot_op_t slot_op(logic mode, logic [3:0] j);
		if (mode && j == 4'd10) return OP_ADD;
		if (mode && j == 4'd11) return OP_MUL;
		if (mode && j == 4'd12) return OP_ADD;
		if (mode && j == 4'd13) return OP_PASS;
		return j[0] ? OP_ADD : OP_MUL;
	endfunction

	function automatic logic [31:0] slot_coef(logic mode, logic [3:0] j);
		logic [3:0] k;
		k = 4'd6 - {1'b0, j[3:1]};
		if (mode && j >= 4'd10) return F_ONE;
		return coef(mode, k[2:0]);
	endfunction

endpackage

// ===== hdl/expf_slot.sv =====
module expf_slot
	import expf_pkg::*;
(
	input  logic        poly_mode,
	input  logic [3:0]  slot_idx,
	input  logic [31:0] r,
	input  logic [31:0] acc_in,
	output logic [31:0] acc_out
);

	// One Horner operation: multiply by r, add a coefficient, or hold.
	always_comb begin
		case (slot_op(poly_mode, slot_idx))
			OP_MUL: acc_out = fp_mul(r, acc_in);
			OP_ADD: acc_out = fp_add(slot_coef(poly_mode, slot_idx), acc_in);
			default: acc_out = acc_in;
		endcase
	end

endmodule

// ===== hdl/expf_polynomial_unit_top.sv =====
// Channel   Dir  Word                       Handshake
// s_*       in   tdata[31:0] = x_bits       tvalid / tready
// m_*       out  tdata[31:0] = y_bits       tvalid / tready
// cfg_*     in   cfg_wdata[0] = poly_mode   cfg_we, no wait
//
// Each word passes through 20 register stages, and one word is taken every cycle when
// nothing stalls. The depth is set by the chain of single rounded operations: the
// reduction multiply, the rounding to n, the two products of the split ln2 in one
// shared stage, two difference steps, fourteen Horner steps and the final scaling
// multiply.
// arst_n clears all valid bits and sets poly_mode to Remez.
// A stall holds only the stages behind a full stage; empty stages keep filling.
module expf_polynomial_unit_top
	import expf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] x_bits
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // [31:0] y_bits
);

	logic mode_q;
	pipe_t pipe_s [1:NumStages];
	pipe_t nxt [1:NumStages];
	logic [NumStages:1] vld_s;
	logic [NumStages+1:1] en;
	logic [31:0] slot_acc [0:NumSlots-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	// A stage may load when it is empty or its own word moves on.
	always_comb begin
		en[NumStages+1] = m_tready;
		for (int k = NumStages; k >= 1; k--) begin
			en[k] = !vld_s[k] || en[k+1];
		end
	end

	assign s_tready = en[1];
	assign m_tvalid = vld_s[NumStages];
	assign m_tdata = pipe_s[NumStages].acc;

	for (genvar j = 0; j < NumSlots; j++) begin : g_slot
		expf_slot u_slot (
			.poly_mode(mode_q),
			.slot_idx (4'(j)),
			.r        (pipe_s[SlotBase+j].r),
			.acc_in   (pipe_s[SlotBase+j].acc),
			.acc_out  (slot_acc[j])
		);
	end

	always_comb begin
		// Stage 1: special values, clamping and x / ln2.
		nxt[1] = pipe_s[1];
		nxt[1].spec = (s_tdata[30:23] == 8'hFF);
		if (s_tdata[22:0] != 23'd0) begin
			nxt[1].sval = F_QNAN;
		end else begin
			nxt[1].sval = s_tdata[31] ? F_ZERO : F_PINF;
		end
		if (s_tdata[30:0] > F_CLAMP[30:0]) begin
			nxt[1].x = s_tdata[31] ? F_CLAMP_NEG : F_CLAMP;
		end else begin
			nxt[1].x = s_tdata;
		end
		nxt[1].a = fp_mul(nxt[1].x, F_INV_LN2);

		// Stage 2: n rounded half away from zero, and n as a float.
		nxt[2] = pipe_s[1];
		nxt[2].n = round_n(pipe_s[1].a);
		nxt[2].a = int_to_fp(nxt[2].n);

		// Stage 3: the two products of the split ln2.
		nxt[3] = pipe_s[2];
		nxt[3].a = fp_mul(pipe_s[2].a, F_LN2_HI);
		nxt[3].b = fp_mul(pipe_s[2].a, F_LN2_LO);

		nxt[4] = pipe_s[3];
		nxt[4].r = fp_sub(pipe_s[3].x, pipe_s[3].a);

		// Stage 5 finishes r and seeds the Horner accumulator.
		nxt[5] = pipe_s[4];
		nxt[5].r = fp_sub(pipe_s[4].r, pipe_s[4].b);
		nxt[5].acc = coef(mode_q, 3'd7);

		for (int j = 0; j < NumSlots; j++) begin
			nxt[SlotBase+1+j] = pipe_s[SlotBase+j];
			nxt[SlotBase+1+j].acc = slot_acc[j];
		end

		// Last stage: scale by 2^n, or pass a special value.
		nxt[NumStages] = pipe_s[NumStages-1];
		if (pipe_s[NumStages-1].spec) begin
			nxt[NumStages].acc = pipe_s[NumStages-1].sval;
		end else begin
			nxt[NumStages].acc = fp_mul(pipe_s[NumStages-1].acc,
				pow2(pipe_s[NumStages-1].n));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[1]) begin
				vld_s[1] <= s_tvalid;
			end
			for (int k = 2; k <= NumStages; k++) begin
				if (en[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 1; k <= NumStages; k++) begin
			if (en[k]) begin
				pipe_s[k] <= nxt[k];
			end
		end
	end

endmodule

// ===== hdl/expf_checker.sv =====
module expf_assert (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	// A held result must stay put until taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// An open output means the whole pipe can move, so the input is open.
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input blocked while output is open");

	// The exponential is never negative.
	a_sign: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !m_tdata[31])
		else $error("negative result");

	// The only NaN produced is the canonical quiet NaN.
	a_nan: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[30:23] == 8'hFF |->
			m_tdata[22:0] == 23'd0 || m_tdata == 32'h7FC00000)
		else $error("non-canonical NaN");

endmodule

bind expf_polynomial_unit_top expf_assert u_expf_assert (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
